/* sv/lag_pkg.sv */
// shared types and constants for the life automaton grid
package lag_pkg;

  // command codes carried in the input beat
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH_IDX  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_IDX = 2'd1;

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] col_x;
    logic [5:0] row_y;
    logic       cell_in;
  } in_item_t;

  typedef struct packed {
    logic cell_out;
    logic status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_LOAD,
    ST_RUN
  } state_t;

endpackage

/* sv/lag_row_mem.sv */
// row memory with per-row valid bits, one read and one write port
module lag_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // rows never written since reset read as all dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* sv/lag_row_engine.sv */
// next-generation row from a three-row window
module lag_row_engine import lag_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] prev_row,
  input  logic [WIDTH-1:0] cur_row,
  input  logic [WIDTH-1:0] next_row,
  input  logic [WIDTH-1:0] col_mask,
  output logic [WIDTH-1:0] new_row
);

  logic [WIDTH+1:0] prev_pad;
  logic [WIDTH+1:0] cur_pad;
  logic [WIDTH+1:0] next_pad;

  // cells beyond the used width count as dead
  assign prev_pad = {1'b0, prev_row & col_mask, 1'b0};
  assign cur_pad  = {1'b0, cur_row & col_mask, 1'b0};
  assign next_pad = {1'b0, next_row & col_mask, 1'b0};

  for (genvar i = 0; i < WIDTH; i++) begin : g_col
    logic [3:0] nbr;
    logic       alive;

    assign nbr = 4'(prev_pad[i]) + 4'(prev_pad[i+1]) + 4'(prev_pad[i+2])
               + 4'(cur_pad[i])                      + 4'(cur_pad[i+2])
               + 4'(next_pad[i]) + 4'(next_pad[i+1]) + 4'(next_pad[i+2]);

    assign alive = (nbr == BIRTH_COUNT) || (cur_row[i] && (nbr == SURVIVE_COUNT));

    // columns outside the used width keep their stored value
    assign new_row[i] = col_mask[i] ? alive : cur_row[i];
  end

endmodule

/* sv/life_automaton_grid.sv */
// top level of the bounded game of life grid with row memory and sweep control
// write and read cells: the accepted beat passes through ST_CELL, where the result beat is registered
// advance: ST_LOAD, then ST_RUN once per used row; the result beat is registered from the last ST_RUN
// the advance sweep is set by the row memory: one row written and at most one row read per cycle
// bad command or position: result beat the cycle after acceptance
// one item at a time: the next input beat can be taken, at the earliest, at the edge that takes the result beat
// reset (rst_n low, synchronous) clears all cells to dead and both size registers to 64
module life_automaton_grid import lag_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int DW   = (WW > HW) ? WW : HW;
  localparam int CMPW = ((DW > 7) ? DW : 7) + 1;

  // size registers, raw as written
  logic [6:0] grid_w_r;
  logic [6:0] grid_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= 7'd64;
      grid_h_r <= 7'd64;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH_IDX:  grid_w_r <= cfg_data;
        CFG_HEIGHT_IDX: grid_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // used sizes: zero acts as one, anything above the maximum is clamped
  logic [CMPW-1:0] w_used;
  logic [CMPW-1:0] h_used;

  always_comb begin
    if (grid_w_r == 7'd0) begin
      w_used = CMPW'(1);
    end else if (CMPW'(grid_w_r) > CMPW'(MAX_WIDTH)) begin
      w_used = CMPW'(MAX_WIDTH);
    end else begin
      w_used = CMPW'(grid_w_r);
    end
    if (grid_h_r == 7'd0) begin
      h_used = CMPW'(1);
    end else if (CMPW'(grid_h_r) > CMPW'(MAX_HEIGHT)) begin
      h_used = CMPW'(MAX_HEIGHT);
    end else begin
      h_used = CMPW'(grid_h_r);
    end
  end

  // one bit per column inside the used width
  logic [MAX_WIDTH-1:0] col_mask;

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
    assign col_mask[i] = CMPW'(i) < w_used;
  end

  // row memory
  logic                 mem_rd_en;
  logic [RW-1:0]        mem_rd_addr;
  logic [MAX_WIDTH-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [RW-1:0]        mem_wr_addr;
  logic [MAX_WIDTH-1:0] mem_wr_data;

  lag_row_mem #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // sweep window: rows above and at the current row, old values
  state_t               state_r, state_nxt;
  logic [HW-1:0]        y_r, y_nxt;
  logic [MAX_WIDTH-1:0] prev_r, prev_nxt;
  logic [MAX_WIDTH-1:0] cur_r, cur_nxt;
  in_item_t             item_r, item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [HW:0]          y_p1;
  logic [HW:0]          y_p2;
  logic                 below_ok;
  logic [MAX_WIDTH-1:0] below_row;
  logic [MAX_WIDTH-1:0] step_row;
  logic                 in_fire;
  logic                 pos_ok;
  logic [CW-1:0]        col_idx;
  logic [MAX_WIDTH-1:0] cell_row;

  assign y_p1      = (HW+1)'(y_r) + (HW+1)'(1);
  assign y_p2      = (HW+1)'(y_r) + (HW+1)'(2);
  // row below the current one exists only inside the used height
  assign below_ok  = CMPW'(y_p1) < h_used;
  assign below_row = below_ok ? mem_rd_data : '0;

  lag_row_engine #(
    .WIDTH (MAX_WIDTH)
  ) u_engine (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (below_row),
    .col_mask (col_mask),
    .new_row  (step_row)
  );

  // idle, and output slot free or being emptied this cycle
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign pos_ok   = (CMPW'(in_data.col_x) < w_used) && (CMPW'(in_data.row_y) < h_used);
  assign col_idx  = CW'(item_r.col_x);

  // single cell update on the fetched row
  always_comb begin
    cell_row          = mem_rd_data;
    cell_row[col_idx] = item_r.cell_in;
  end

  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          case (in_data.command)
            CMD_WRITE, CMD_READ: begin
              if (pos_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = RW'(in_data.row_y);
                state_nxt   = ST_CELL;
              end else begin
                out_valid_nxt         = 1'b1;
                out_data_nxt.cell_out = 1'b0;
                out_data_nxt.status   = 1'b1;
              end
            end
            CMD_STEP: begin
              // fetch the top row, the row above it is dead
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_nxt   = ST_LOAD;
            end
            default: begin
              out_valid_nxt         = 1'b1;
              out_data_nxt.cell_out = 1'b0;
              out_data_nxt.status   = 1'b1;
            end
          endcase
        end
      end

      ST_CELL: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = 1'b0;
        if (item_r.command == CMD_WRITE) begin
          mem_wr_en             = 1'b1;
          mem_wr_addr           = RW'(item_r.row_y);
          mem_wr_data           = cell_row;
          out_data_nxt.cell_out = 1'b0;
        end else begin
          out_data_nxt.cell_out = mem_rd_data[col_idx];
        end
        state_nxt = ST_IDLE;
      end

      ST_LOAD: begin
        prev_nxt = '0;
        cur_nxt  = mem_rd_data;
        y_nxt    = '0;
        if (h_used > CMPW'(1)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = RW'(1);
        end
        state_nxt = ST_RUN;
      end

      ST_RUN: begin
        // write back row y while the row two below, if inside the used height, is fetched
        mem_wr_en   = 1'b1;
        mem_wr_addr = y_r[RW-1:0];
        mem_wr_data = step_row;
        if (!below_ok) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.cell_out = 1'b0;
          out_data_nxt.status   = 1'b0;
          state_nxt             = ST_IDLE;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = mem_rd_data;
          y_nxt    = y_p1[HW-1:0];
          if (CMPW'(y_p2) < h_used) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = y_p2[RW-1:0];
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and window registers
  always_ff @(posedge clk) begin
    y_r        <= y_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/life_automaton_grid_test.sv */
`timescale 1ns / 1ps
// self-checking bench for the life automaton grid: directed patterns, then random phases
module life_automaton_grid_test;
  import lag_pkg::*;

  // grid bounds as built into the block
  localparam int GRID_MAX = 64;

  // codes that the package leaves out
  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam logic [1:0] CFG_SPARE_A_IDX = 2'd2;
  localparam logic [1:0] CFG_SPARE_B_IDX = 2'd3;

  localparam int CLK_HALF      = 4;
  localparam int ITEM_TARGET   = 1950;
  // from here on neither side inserts random idles
  localparam int QUIET_AFTER   = 1700;
  // quiet cycles before a register write, once every result is back
  localparam int SETTLE_CYCLES = 4;
  // a full 64-row sweep passes ST_LOAD and one ST_RUN per row before its beat
  localparam int DRAIN_CYCLES  = 80;
  // cycles with no beat on either side before the run is called hung
  localparam int STALL_LIMIT   = 2000;

  typedef logic [GRID_MAX-1:0] grid_t [GRID_MAX];

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  // predicted grid and size registers
  grid_t      live_cells;
  logic [6:0] width_reg;
  logic [6:0] height_reg;

  out_item_t  expected_results[$];
  int         items_counted = 0;
  int         results_seen  = 0;
  int         mismatches    = 0;
  int         idle_cycles;
  bit         quiet = 1'b0;

  life_automaton_grid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // a size of zero acts as one, anything past the maximum acts as the maximum
  function automatic int used_extent(logic [6:0] size_reg);
    if (size_reg == 0) return 1;
    if (size_reg > GRID_MAX) return GRID_MAX;
    return int'(size_reg);
  endfunction

  // one B3/S23 generation over the used area; everything outside it is dead
  // to its neighbours and keeps its stored value
  function automatic void advance_generation();
    grid_t next_cells;
    int    w;
    int    h;
    int    n;
    int    yy;
    int    xx;
    w = used_extent(width_reg);
    h = used_extent(height_reg);
    next_cells = live_cells;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            yy = y + dy;
            xx = x + dx;
            if ((dy != 0 || dx != 0) && yy >= 0 && xx >= 0 && yy < h && xx < w)
              n += int'(live_cells[yy][xx]);
          end
        end
        if (live_cells[y][x])
          next_cells[y][x] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
        else
          next_cells[y][x] = (n == BIRTH_COUNT);
      end
    end
    live_cells = next_cells;
  endfunction

  // applies one accepted beat to the predicted grid and gives its result
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int        w;
    int        h;
    r = '0;
    w = used_extent(width_reg);
    h = used_extent(height_reg);
    case (it.command)
      CMD_STEP: advance_generation();
      CMD_WRITE, CMD_READ: begin
        if (it.col_x >= w || it.row_y >= h)
          r.status = 1'b1;
        else if (it.command == CMD_WRITE)
          live_cells[it.row_y][it.col_x] = it.cell_in;
        else
          r.cell_out = live_cells[it.row_y][it.col_x];
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  function automatic in_item_t cell_cmd(logic [1:0] cmd, int x, int y, logic v);
    in_item_t it;
    it.command = cmd;
    it.col_x   = 6'(x);
    it.row_y   = 6'(y);
    it.cell_in = v;
    return it;
  endfunction

  // one input beat: optional idle burst, hold valid until taken, then predict
  task automatic send_cell_command(in_item_t it);
    out_item_t want;
    if (!quiet && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 11)) @(negedge clk);
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_result(it);
    expected_results = {expected_results, want};
    // ignored beats do not count toward the item total
    if (!want.status) items_counted++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // register writes only once the block has gone quiet
  task automatic write_size_reg(logic [1:0] idx, logic [6:0] value);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == CFG_WIDTH_IDX)
      width_reg = value;
    else if (idx == CFG_HEIGHT_IDX)
      height_reg = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // result side: random back-pressure bursts, none in the last part
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [1:0] want, logic [1:0] got);
    $display("%0t mismatch on result beat %0d: %s, expected %b got %b",
             $time, results_seen, what, want, got);
    mismatches++;
  endtask

  // every result beat is matched against the oldest prediction
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing outstanding", 2'bxx, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.cell_out !== want.cell_out)
            report_mismatch("cell_out", {1'b0, want.cell_out}, {1'b0, out_data.cell_out});
          if (out_data.status !== want.status)
            report_mismatch("status", {1'b0, want.status}, {1'b0, out_data.status});
        end
        results_seen++;
      end
    end
  end

  // hang detection: any beat on either channel restarts the count
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("life_automaton_grid test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full 64 x 64 grid straight after reset: corners, write-back, lone cells dying
  task automatic test_reset_grid();
    send_cell_command(cell_cmd(CMD_READ, 63, 63, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 0, 0, 1'b0));
    send_cell_command(cell_cmd(CMD_WRITE, 0, 0, 1'b1));
    send_cell_command(cell_cmd(CMD_WRITE, 63, 63, 1'b1));
    send_cell_command(cell_cmd(CMD_READ, 0, 0, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 63, 63, 1'b0));
    send_cell_command(cell_cmd(CMD_STEP, 0, 0, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 63, 63, 1'b0));
  endtask

  // unused command, size clamping at both ends, spare register indexes,
  // positions just past the used area
  task automatic test_range_and_bad_command();
    send_cell_command(cell_cmd(CMD_UNUSED, 63, 63, 1'b1));
    write_size_reg(CFG_WIDTH_IDX, 7'd0);
    write_size_reg(CFG_HEIGHT_IDX, 7'd127);
    write_size_reg(CFG_SPARE_A_IDX, 7'h7f);
    write_size_reg(CFG_SPARE_B_IDX, 7'h55);
    send_cell_command(cell_cmd(CMD_WRITE, 0, 10, 1'b1));
    send_cell_command(cell_cmd(CMD_WRITE, 1, 10, 1'b1));
    send_cell_command(cell_cmd(CMD_READ, 0, 10, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 63, 63, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 0, 63, 1'b0));
    send_cell_command(cell_cmd(CMD_STEP, 0, 0, 1'b0));
  endtask

  // blinker filling a 3 x 3 grid, so every neighbour count touches an edge
  task automatic test_blinker_at_edge();
    write_size_reg(CFG_WIDTH_IDX, 7'd3);
    write_size_reg(CFG_HEIGHT_IDX, 7'd3);
    send_cell_command(cell_cmd(CMD_WRITE, 1, 0, 1'b1));
    send_cell_command(cell_cmd(CMD_WRITE, 1, 1, 1'b1));
    send_cell_command(cell_cmd(CMD_WRITE, 1, 2, 1'b1));
    send_cell_command(cell_cmd(CMD_STEP, 0, 0, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 0, 1, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 2, 1, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 1, 0, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 1, 2, 1'b0));
    send_cell_command(cell_cmd(CMD_STEP, 0, 0, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 1, 0, 1'b0));
    send_cell_command(cell_cmd(CMD_READ, 0, 1, 1'b0));
  endtask

  // mostly small grids so sweeps are short, now and then the extremes
  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 7'($urandom_range(0, 1));
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      3: return 7'($urandom_range(1, 127));
      default: return 7'($urandom_range(3, 12));
    endcase
  endfunction

  // stray beat: past the used area, the unused command, or anything at all
  function automatic in_item_t stray_item(int w, int h);
    in_item_t it;
    it = cell_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                  $urandom_range(0, GRID_MAX - 1), $urandom_range(0, GRID_MAX - 1),
                  1'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0: if (w < GRID_MAX) it.col_x = 6'($urandom_range(w, GRID_MAX - 1));
      1: if (h < GRID_MAX) it.row_y = 6'($urandom_range(h, GRID_MAX - 1));
      2: it.command = CMD_UNUSED;
      default: ;
    endcase
    return it;
  endfunction

  // each phase: resize, seed a pattern, then run generations with reads between;
  // the grid is never cleared, so cells left outside a shrunk area come back later
  task automatic test_random_phases();
    int w;
    int h;
    int seeds;
    while (items_counted < ITEM_TARGET) begin
      if (items_counted >= QUIET_AFTER) quiet = 1'b1;
      write_size_reg(CFG_WIDTH_IDX, pick_size());
      write_size_reg(CFG_HEIGHT_IDX, pick_size());
      if ($urandom_range(0, 5) == 0)
        write_size_reg($urandom_range(0, 1) ? CFG_SPARE_A_IDX : CFG_SPARE_B_IDX,
                       7'($urandom_range(0, 127)));
      w = used_extent(width_reg);
      h = used_extent(height_reg);
      // seeding leans towards live cells so patterns survive a few generations
      seeds = $urandom_range(1, (w * h < 40) ? w * h : 40);
      repeat (seeds)
        send_cell_command(cell_cmd(CMD_WRITE, $urandom_range(0, w - 1),
                                   $urandom_range(0, h - 1), $urandom_range(0, 3) != 0));
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(1, 3))
          send_cell_command(cell_cmd(CMD_STEP, $urandom_range(0, 63),
                                     $urandom_range(0, 63), 1'($urandom_range(0, 1))));
        repeat ($urandom_range(2, 8))
          send_cell_command(cell_cmd(CMD_READ, $urandom_range(0, w - 1),
                                     $urandom_range(0, h - 1), 1'($urandom_range(0, 1))));
        // occasional edit between generations
        repeat ($urandom_range(0, 2))
          send_cell_command(cell_cmd(CMD_WRITE, $urandom_range(0, w - 1),
                                     $urandom_range(0, h - 1), 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 3) == 0)
          send_cell_command(stray_item(w, h));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    foreach (live_cells[i]) live_cells[i] = '0;
    width_reg  = 7'd64;
    height_reg = 7'd64;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_grid();
    test_range_and_bad_command();
    test_blinker_at_edge();
    test_random_phases();

    // let the last sweep finish and catch any extra beats
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("predicted beats never delivered", 2'bxx, 2'bxx);

    if (mismatches == 0)
      $display("life_automaton_grid test passed");
    else
      $display("life_automaton_grid test failed");
    $finish;
  end

endmodule
